// ===== hdl/mei_pkg.sv =====
// shared constants, item type and width helper for the escape-time iterator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mei_pkg;

    localparam int FRAC_BITS_DEF   = 28;
    localparam int C_W             = 32;
    localparam int CFG_W           = 16;
    localparam int CNT_W           = 17;
    localparam int DIGIT_W         = 16;
    localparam int QUEUE_DEPTH     = 2;
    // escape radius 2, so the limit on |z|^2 is 2^(2*(frac + 1))
    localparam int ESC_RADIUS_LOG2 = 1;

    localparam logic [CFG_W-1:0] MAX_ITER_RESET = CFG_W'(1024 - 1);

    typedef struct packed {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic                  far;
    } t_item;

    // bits of |z| after one update from a point inside the radius:
    // |z^2 term| <= 4 and |c| < 2^(C_W-1) lsb
    function automatic int mag_width(input int frac);
        logic [63:0] bound;
        bound = (64'd1 << (frac + 2)) + (64'd1 << (C_W - 1)) + 64'd1;
        return $clog2(bound);
    endfunction

endpackage

// ===== hdl/mandelbrot_escape_iterator_unit.sv =====
// escape-time iterator: one point per item, one result item per point.
// each step runs three multiplies of |z|, taken in 16-bit digits; a point with
// |cx| or |cy| > 2 skips the steps and is done with a count of one.
// one point iterates at a time; the input queue holds two more and the output
// register lets the next point start while a result waits.
// synchronous active-low reset clears control state, max_iterations to 1023.
`timescale 1ns / 1ps

module mandelbrot_escape_iterator_unit #(
    parameter int FRAC_BITS = mei_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [mei_pkg::C_W-1:0] i_cx,
    input  logic signed [mei_pkg::C_W-1:0] i_cy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mei_pkg::CNT_W-1:0]     o_iteration_count,
    output logic                          o_in_set,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mei_pkg::CFG_W-1:0]     i_max_iterations
);
    import mei_pkg::*;

    localparam int MW = mag_width(FRAC_BITS);

    logic [CFG_W-1:0] r_max_iter;
    logic             w_item_valid;
    t_item            w_item;
    logic             w_pop;
    logic             w_mul_start;
    logic [MW-1:0]    w_mul_a;
    logic [MW-1:0]    w_mul_b;
    logic             w_mul_done;
    logic [2*MW-1:0]  w_mul_prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_iter <= i_max_iterations;
        end
    end

    mei_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cx         (i_cx),
        .i_cy         (i_cy),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    mei_mul #(
        .MW (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    mei_core #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (w_item_valid),
        .i_item            (w_item),
        .o_pop             (w_pop),
        .i_max_iter        (r_max_iter),
        .o_mul_start       (w_mul_start),
        .o_mul_a           (w_mul_a),
        .o_mul_b           (w_mul_b),
        .i_mul_done        (w_mul_done),
        .i_mul_prod        (w_mul_prod),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_iteration_count (o_iteration_count),
        .o_in_set          (o_in_set)
    );

    // in-set flag agrees with the delivered count and the limit
    a_inset_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_in_set == (o_iteration_count > CNT_W'(r_max_iter))))
        else $error("in_set does not match iteration count");

    // count never stops before the first step nor runs past the limit plus one
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_iteration_count != '0) &&
                         (o_iteration_count <= CNT_W'(r_max_iter) + CNT_W'(1))))
        else $error("iteration count out of range");

endmodule

// ===== hdl/mei_front.sv =====
// front end: takes points, flags points that surely escape on the first step,
// and queues them for the iterator; uses mei_pkg
`timescale 1ns / 1ps

module mei_front #(
    parameter int FRAC_BITS = mei_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [mei_pkg::C_W-1:0] i_cx,
    input  logic signed [mei_pkg::C_W-1:0] i_cy,
    output logic                          o_item_valid,
    output mei_pkg::t_item                o_item,
    input  logic                          i_pop
);
    import mei_pkg::*;

    localparam int MW = mag_width(FRAC_BITS);
    localparam int ZW = MW + 1;
    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(QUEUE_DEPTH + 1);
    localparam logic [MW-1:0] FAR_LIM = MW'(1) << (FRAC_BITS + ESC_RADIUS_LOG2);
    localparam logic [QA-1:0] LAST_PTR = QA'(QUEUE_DEPTH - 1);
    localparam logic [QC-1:0] FULL_CNT = QC'(QUEUE_DEPTH);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QA-1:0]     r_wr_ptr;
    logic [QA-1:0]     r_rd_ptr;
    logic [QC-1:0]     r_count;
    logic [QA-1:0]     n_wr_ptr;
    logic [QA-1:0]     n_rd_ptr;
    logic [QC-1:0]     n_count;
    logic signed [ZW-1:0] w_sx;
    logic signed [ZW-1:0] w_sy;
    logic signed [ZW-1:0] w_ax;
    logic signed [ZW-1:0] w_ay;
    logic              w_push;
    logic              w_pop;
    t_item             w_new;

    // |cx| or |cy| beyond 2 means |c|^2 > 4, so the first step already escapes
    assign w_sx = ZW'(i_cx);
    assign w_sy = ZW'(i_cy);
    assign w_ax = w_sx[ZW-1] ? -w_sx : w_sx;
    assign w_ay = w_sy[ZW-1] ? -w_sy : w_sy;

    assign w_new.cx  = i_cx;
    assign w_new.cy  = i_cy;
    assign w_new.far = (w_ax[MW-1:0] > FAR_LIM) || (w_ay[MW-1:0] > FAR_LIM);

    assign o_in_stall   = (r_count == FULL_CNT);
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    assign w_push = i_in_valid && !o_in_stall;
    assign w_pop  = i_pop && o_item_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + QA'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + QA'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + QC'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QC'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_new;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/mei_mul.sv =====
// iterative unsigned multiplier, one 16-bit digit of b per cycle, msb first
// registered digit product before the accumulate; uses mei_pkg
`timescale 1ns / 1ps

module mei_mul #(
    parameter int MW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    output logic            o_done,
    output logic [2*MW-1:0] o_prod
);
    import mei_pkg::*;

    localparam int PW  = 2 * MW;
    localparam int NCH = (MW + DIGIT_W - 1) / DIGIT_W;
    localparam int BW  = NCH * DIGIT_W;
    localparam int CW  = $clog2(NCH + 1);
    localparam int XW  = MW + DIGIT_W;
    localparam logic [CW-1:0] LAST = CW'(NCH);

    logic [MW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [XW-1:0] r_pp;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BW'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != LAST) begin
                r_pp <= XW'(r_a) * XW'(r_b[BW-1 -: DIGIT_W]);
                r_b  <= {r_b[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end
            // product of the previous digit joins the running sum
            if (r_cnt != '0) begin
                r_acc <= {r_acc[PW-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PW'(r_pp);
            end
        end

        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_busy <= (r_cnt != LAST);
                r_cnt  <= r_cnt + CW'(1);
            end
        end
    end

endmodule

// ===== hdl/mei_core.sv =====
// back end: runs z = z*z + c on one point with the shared multiplier,
// counts steps and holds the result in an output register; uses mei_pkg
`timescale 1ns / 1ps

module mei_core #(
    parameter int FRAC_BITS = mei_pkg::FRAC_BITS_DEF,
    parameter int MW        = mei_pkg::mag_width(mei_pkg::FRAC_BITS_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  mei_pkg::t_item              i_item,
    output logic                        o_pop,
    input  logic [mei_pkg::CFG_W-1:0]   i_max_iter,
    output logic                        o_mul_start,
    output logic [MW-1:0]               o_mul_a,
    output logic [MW-1:0]               o_mul_b,
    input  logic                        i_mul_done,
    input  logic [2*MW-1:0]             i_mul_prod,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mei_pkg::CNT_W-1:0]   o_iteration_count,
    output logic                        o_in_set
);
    import mei_pkg::*;

    localparam int ZW = MW + 1;
    localparam int PW = 2 * MW;
    localparam int VW = PW + 2;
    localparam logic [PW:0] LIMIT = (PW + 1)'(1) << (2 * (FRAC_BITS + ESC_RADIUS_LOG2));

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_MXX,
        S_MYY,
        S_MXY,
        S_TEST,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic signed [C_W-1:0] r_cx, n_cx;
    logic signed [C_W-1:0] r_cy, n_cy;
    logic signed [ZW-1:0] r_zx, n_zx;
    logic signed [ZW-1:0] r_zy, n_zy;
    logic signed [ZW-1:0] r_fx, n_fx;
    logic signed [ZW-1:0] r_fy, n_fy;
    logic [PW-1:0]        r_sx, n_sx;
    logic [PW-1:0]        r_sy, n_sy;
    logic [PW-1:0]        r_pxy, n_pxy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_mstart, n_mstart;
    logic                 r_ovalid, n_ovalid;
    logic [CNT_W-1:0]     r_ocount, n_ocount;
    logic                 r_oinset, n_oinset;

    logic signed [ZW-1:0] w_absx;
    logic signed [ZW-1:0] w_absy;
    logic [MW-1:0]        w_magx;
    logic [MW-1:0]        w_magy;
    logic [PW:0]          w_sum;
    logic                 w_esc;
    logic [CNT_W-1:0]     w_cnt_inc;
    logic                 w_stop;
    logic [CNT_W-1:0]     w_max;
    logic                 w_pneg;
    logic signed [VW-1:0] w_two;
    logic signed [VW-1:0] w_vy;
    logic signed [VW-1:0] w_vx;
    logic signed [VW-1:0] w_vy_sh;
    logic signed [VW-1:0] w_vx_sh;
    logic                 w_out_free;

    assign w_absx = r_zx[ZW-1] ? -r_zx : r_zx;
    assign w_absy = r_zy[ZW-1] ? -r_zy : r_zy;
    assign w_magx = w_absx[MW-1:0];
    assign w_magy = w_absy[MW-1:0];

    // escape test on the squares of the freshly updated z
    assign w_sum     = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_esc     = (w_sum > LIMIT);
    assign w_max     = CNT_W'(i_max_iter);
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    assign w_stop    = w_esc || (w_cnt_inc > w_max);

    // floor scaling of 2*zx*zy and zx^2 - zy^2 for the next update
    assign w_pneg  = r_zx[ZW-1] ^ r_zy[ZW-1];
    assign w_two   = $signed({1'b0, r_pxy, 1'b0});
    assign w_vy    = w_pneg ? -w_two : w_two;
    assign w_vx    = $signed({2'b00, r_sx}) - $signed({2'b00, r_sy});
    assign w_vy_sh = w_vy >>> FRAC_BITS;
    assign w_vx_sh = w_vx >>> FRAC_BITS;

    assign w_out_free = !r_ovalid || !i_out_stall;

    assign o_pop             = (r_state == S_IDLE) && i_item_valid;
    assign o_mul_start       = r_mstart;
    assign o_out_valid       = r_ovalid;
    assign o_iteration_count = r_ocount;
    assign o_in_set          = r_oinset;

    always_comb begin
        unique case (r_state)
            S_MXX: begin
                o_mul_a = w_magx;
                o_mul_b = w_magx;
            end
            S_MYY: begin
                o_mul_a = w_magy;
                o_mul_b = w_magy;
            end
            default: begin
                o_mul_a = w_magx;
                o_mul_b = w_magy;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_zx     = r_zx;
        n_zy     = r_zy;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_pxy    = r_pxy;
        n_cnt    = r_cnt;
        n_mstart = 1'b0;
        n_ovalid = r_ovalid && i_out_stall;
        n_ocount = r_ocount;
        n_oinset = r_oinset;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_cx = i_item.cx;
                    n_cy = i_item.cy;
                    n_fx = '0;
                    n_fy = '0;
                    if (i_item.far) begin
                        n_cnt   = CNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                n_zx     = r_fx + ZW'(r_cx);
                n_zy     = r_fy + ZW'(r_cy);
                n_mstart = 1'b1;
                n_state  = S_MXX;
            end
            S_MXX: begin
                if (i_mul_done) begin
                    n_sx     = i_mul_prod;
                    n_mstart = 1'b1;
                    n_state  = S_MYY;
                end
            end
            S_MYY: begin
                if (i_mul_done) begin
                    n_sy     = i_mul_prod;
                    n_mstart = 1'b1;
                    n_state  = S_MXY;
                end
            end
            S_MXY: begin
                if (i_mul_done) begin
                    n_pxy   = i_mul_prod;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                n_fx    = $signed(w_vx_sh[ZW-1:0]);
                n_fy    = $signed(w_vy_sh[ZW-1:0]);
                n_cnt   = w_cnt_inc;
                n_state = w_stop ? S_DONE : S_UPD;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ocount = r_cnt;
                    n_oinset = (r_cnt > w_max);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_zx     <= n_zx;
        r_zy     <= n_zy;
        r_fx     <= n_fx;
        r_fy     <= n_fy;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_pxy    <= n_pxy;
        r_cnt    <= n_cnt;
        r_ocount <= n_ocount;
        r_oinset <= n_oinset;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mstart <= n_mstart;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
